FILE: hw/rtl/ac_phase_and_rms_meter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the phase and RMS meter
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef AC_PHASE_AND_RMS_METER_TOP_DEFINES_SVH
`define AC_PHASE_AND_RMS_METER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Condition holds at every edge.
`define ACPRM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("acprm check failed");
// Consequent holds at the same edge as the antecedent.
`define ACPRM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acprm check failed");
// Consequent holds at the edge after the antecedent.
`define ACPRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acprm check failed");
`else
`define ACPRM_ASSERT_ALWAYS(lbl, expr)
`define ACPRM_ASSERT_IMPLY(lbl, ante, cons)
`define ACPRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/acprm_pkg.sv
// ----------------------------------------------------------------------------
// acprm_pkg
// Types and constants shared by the phase and RMS meter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package acprm_pkg;

  // Input request: one timer tick.
  typedef struct packed {
    logic       ref_level;
    logic       test_level;
    logic [9:0] ref_sample;
    logic [9:0] test_sample;
  } in_item_t;

  // Result request: one finished measurement.
  typedef struct packed {
    logic [23:0] period_ticks;
    logic [12:0] ref_rms_mv;
    logic [12:0] test_rms_mv;
    logic [23:0] delay_ticks;
    logic [15:0] phase_centideg;
  } out_item_t;

  // Job fields are sized for the largest counter and ADC widths.
  typedef logic [31:0] job_cnt_t;
  typedef logic [15:0] job_adc_t;

  typedef struct packed {
    job_cnt_t period;
    job_cnt_t delay;
    job_adc_t ref_peak;
    job_adc_t test_peak;
  } job_t;

  // Push side of the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  // Sequencer phases of the front part.
  typedef enum logic [3:0] {
    SEQ_PER_WAIT_LOW   = 4'd0,
    SEQ_PER_WAIT_HIGH  = 4'd1,
    SEQ_PER_CNT_HIGH   = 4'd2,
    SEQ_PER_CNT_LOW    = 4'd3,
    SEQ_RPK_WAIT_LOW   = 4'd4,
    SEQ_RPK_WAIT_HIGH  = 4'd5,
    SEQ_RPK_QUARTER    = 4'd6,
    SEQ_TPK_WAIT_LOW   = 4'd7,
    SEQ_TPK_WAIT_HIGH  = 4'd8,
    SEQ_TPK_QUARTER    = 4'd9,
    SEQ_DLY_WAIT_LOW   = 4'd10,
    SEQ_DLY_WAIT_HIGH  = 4'd11,
    SEQ_DLY_COUNT      = 4'd12
  } seq_phase_t;

  // States of the back part.
  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_MUL_A  = 3'd1,
    BK_MUL_B  = 3'd2,
    BK_PH_MUL = 3'd3,
    BK_DIV    = 3'd4,
    BK_OUT    = 3'd5
  } back_state_t;

  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
  localparam logic [15:0] PHASE_SCALE   = 16'd36000;
  localparam logic [15:0] PHASE_MAX     = 16'd35999;
  localparam logic [12:0] RMS_MAX       = 13'd8191;
  localparam logic [23:0] OUT24_MAX     = 24'hFFFFFF;
  localparam logic [12:0] FS_RESET      = 13'd3300;
  localparam int          DIV_STEPS     = 16;
  localparam int          Q_DEPTH       = 2;

endpackage

`default_nettype wire

FILE: hw/rtl/acprm_front.sv
// ----------------------------------------------------------------------------
// acprm_front
// Tick sequencer: measures the period, captures both peaks, counts the delay
// and hands one job to the queue at the end of each sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ac_phase_and_rms_meter_top_defines.svh"

module acprm_front #(
  parameter int COUNT_WIDTH = 24,
  parameter int ADC_BITS    = 10
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  acprm_pkg::in_item_t in_data,
  input  wire                 q_full,
  output acprm_pkg::job_push_t push
);

  acprm_pkg::seq_phase_t    phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [COUNT_WIDTH-1:0]   period_r, period_nxt;
  logic [ADC_BITS-1:0]      ref_pk_r, ref_pk_nxt;
  logic [ADC_BITS-1:0]      test_pk_r, test_pk_nxt;
  logic [ADC_BITS-1:0]      rs, ts;
  logic                     acc;
  logic                     emit;
  logic [COUNT_WIDTH-1:0]   emit_delay;
  logic                     quarter_done;

  // Hold ticks back only while no job slot is free.
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  assign rs = ADC_BITS'(in_data.ref_sample);
  assign ts = ADC_BITS'(in_data.test_sample);

  // Saturating tick counter increment and quarter-period test.
  assign cnt_inc      = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign quarter_done = (cnt_inc >= (period_r >> 2));

  // Sequencer state register and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= acprm_pkg::SEQ_PER_WAIT_LOW;
      cnt_r     <= '0;
      period_r  <= '0;
      ref_pk_r  <= '0;
      test_pk_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      period_r  <= period_nxt;
      ref_pk_r  <= ref_pk_nxt;
      test_pk_r <= test_pk_nxt;
    end
  end

  // Next phase, counters and captured values for one accepted tick.
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    period_nxt  = period_r;
    ref_pk_nxt  = ref_pk_r;
    test_pk_nxt = test_pk_r;
    emit        = 1'b0;
    emit_delay  = '0;
    if (acc) begin
      case (phase_r)
        acprm_pkg::SEQ_PER_WAIT_LOW,
        acprm_pkg::SEQ_RPK_WAIT_LOW,
        acprm_pkg::SEQ_DLY_WAIT_LOW: begin
          if (!in_data.ref_level) phase_nxt = acprm_pkg::seq_phase_t'(phase_r + 4'd1);
        end
        acprm_pkg::SEQ_TPK_WAIT_LOW: begin
          if (!in_data.test_level) phase_nxt = acprm_pkg::SEQ_TPK_WAIT_HIGH;
        end
        acprm_pkg::SEQ_PER_WAIT_HIGH,
        acprm_pkg::SEQ_RPK_WAIT_HIGH: begin
          if (in_data.ref_level) begin
            cnt_nxt   = '0;
            phase_nxt = acprm_pkg::seq_phase_t'(phase_r + 4'd1);
          end
        end
        acprm_pkg::SEQ_TPK_WAIT_HIGH: begin
          if (in_data.test_level) begin
            cnt_nxt   = '0;
            phase_nxt = acprm_pkg::SEQ_TPK_QUARTER;
          end
        end
        acprm_pkg::SEQ_PER_CNT_HIGH: begin
          cnt_nxt = cnt_inc;
          if (!in_data.ref_level) phase_nxt = acprm_pkg::SEQ_PER_CNT_LOW;
        end
        acprm_pkg::SEQ_PER_CNT_LOW: begin
          cnt_nxt = cnt_inc;
          if (in_data.ref_level) begin
            period_nxt = cnt_inc;
            phase_nxt  = acprm_pkg::SEQ_RPK_WAIT_LOW;
          end
        end
        acprm_pkg::SEQ_RPK_QUARTER: begin
          cnt_nxt = cnt_inc;
          if (quarter_done) begin
            ref_pk_nxt = rs;
            phase_nxt  = acprm_pkg::SEQ_TPK_WAIT_LOW;
          end
        end
        acprm_pkg::SEQ_TPK_QUARTER: begin
          cnt_nxt = cnt_inc;
          if (quarter_done) begin
            test_pk_nxt = ts;
            phase_nxt   = acprm_pkg::SEQ_DLY_WAIT_LOW;
          end
        end
        acprm_pkg::SEQ_DLY_WAIT_HIGH: begin
          if (in_data.ref_level) begin
            cnt_nxt = '0;
            if (in_data.test_level) begin
              // Test already high at the reference rise: zero delay.
              emit      = 1'b1;
              phase_nxt = acprm_pkg::SEQ_PER_WAIT_LOW;
            end else begin
              phase_nxt = acprm_pkg::SEQ_DLY_COUNT;
            end
          end
        end
        acprm_pkg::SEQ_DLY_COUNT: begin
          cnt_nxt = cnt_inc;
          if (in_data.test_level) begin
            emit       = 1'b1;
            emit_delay = cnt_inc;
            phase_nxt  = acprm_pkg::SEQ_PER_WAIT_LOW;
          end
        end
        default: begin
          phase_nxt = acprm_pkg::SEQ_PER_WAIT_LOW;
        end
      endcase
    end
  end

  // Job handed to the queue.
  assign push.valid         = emit;
  assign push.job.period    = acprm_pkg::job_cnt_t'(period_r);
  assign push.job.delay     = acprm_pkg::job_cnt_t'(emit_delay);
  assign push.job.ref_peak  = acprm_pkg::job_adc_t'(ref_pk_r);
  assign push.job.test_peak = acprm_pkg::job_adc_t'(test_pk_r);

  `ACPRM_ASSERT_IMPLY(a_push_from_delay_phase, push.valid, (phase_r == acprm_pkg::SEQ_DLY_WAIT_HIGH) || (phase_r == acprm_pkg::SEQ_DLY_COUNT))
  `ACPRM_ASSERT_IMPLY(a_push_on_accept, push.valid, acc && !q_full)
  `ACPRM_ASSERT_NEXT(a_period_nonzero, acc && (phase_r == acprm_pkg::SEQ_PER_CNT_LOW) && in_data.ref_level, period_r != '0)

endmodule

`default_nettype wire

FILE: hw/rtl/acprm_queue.sv
// ----------------------------------------------------------------------------
// acprm_queue
// Two-entry job queue between the sequencer and the arithmetic back part.
// ----------------------------------------------------------------------------
`default_nettype none

module acprm_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  acprm_pkg::job_push_t push,
  output logic                 full,
  output logic                 head_valid,
  output acprm_pkg::job_t      head,
  input  wire                  pop
);

  localparam int PW = $clog2(acprm_pkg::Q_DEPTH);

  acprm_pkg::job_t  mem_r [acprm_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == (PW+1)'(acprm_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.job;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/acprm_back.sv
// ----------------------------------------------------------------------------
// acprm_back
// Arithmetic back part: scales both peaks to RMS millivolts on a shared
// multiplier, forms the phase by a bit-serial divide and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ac_phase_and_rms_meter_top_defines.svh"

module acprm_back #(
  parameter int COUNT_WIDTH = 24,
  parameter int ADC_BITS    = 10
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [12:0]          full_scale_mv,
  input  wire                  job_valid,
  input  acprm_pkg::job_t      job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output acprm_pkg::out_item_t out_data
);

  localparam int M1_W  = ADC_BITS + 13;
  localparam int M2_W  = ADC_BITS + 30;
  localparam int NUM_W = COUNT_WIDTH + 16;
  localparam int SH    = ADC_BITS + 16;

  acprm_pkg::back_state_t  state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  acprm_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [COUNT_WIDTH-1:0]  period_r, period_nxt;
  logic [COUNT_WIDTH-1:0]  delay_r, delay_nxt;
  logic [ADC_BITS-1:0]     ref_pk_r, ref_pk_nxt;
  logic [ADC_BITS-1:0]     test_pk_r, test_pk_nxt;
  logic                    sel_r, sel_nxt;
  logic [M1_W-1:0]         m1_r, m1_nxt;
  logic [12:0]             ref_rms_r, ref_rms_nxt;
  logic [12:0]             test_rms_r, test_rms_nxt;
  logic [COUNT_WIDTH-1:0]  rem_r, rem_nxt;
  logic [15:0]             low_r, low_nxt;
  logic [15:0]             quo_r, quo_nxt;
  logic [3:0]              step_r, step_nxt;
  logic                    sat_r, sat_nxt;
  logic                    zero_r, zero_nxt;

  logic [ADC_BITS-1:0]     peak_sel;
  logic [M2_W-1:0]         m2, m2_rnd, m2_sh;
  logic [12:0]             rms_val;
  logic [NUM_W-1:0]        num;
  logic [COUNT_WIDTH:0]    trial;
  logic                    trial_ge;
  logic [15:0]             phase_val;
  logic [31:0]             per32, dly32;

  // RMS datapath: second multiply, round half up, scale down and clamp.
  assign peak_sel = sel_r ? test_pk_r : ref_pk_r;
  assign m2       = M2_W'(m1_r) * M2_W'(acprm_pkg::INV_SQRT2_Q16);
  assign m2_rnd   = m2 + (M2_W'(1) << (SH - 1));
  assign m2_sh    = m2_rnd >> SH;
  assign rms_val  = (m2_sh > M2_W'(acprm_pkg::RMS_MAX)) ? acprm_pkg::RMS_MAX : m2_sh[12:0];

  // Phase numerator and one restoring divide step.
  assign num      = NUM_W'(delay_r) * NUM_W'(acprm_pkg::PHASE_SCALE);
  assign trial    = {rem_r, low_r[15]};
  assign trial_ge = (trial >= {1'b0, period_r});

  // Phase is zero for a zero period and saturates once delay reaches a period.
  assign phase_val = zero_r ? 16'd0 : (sat_r ? acprm_pkg::PHASE_MAX : quo_r);

  // 24-bit output saturation on the counted values.
  assign per32 = 32'(period_r);
  assign dly32 = 32'(delay_r);

  // State register and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acprm_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      step_r      <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    period_r   <= period_nxt;
    delay_r    <= delay_nxt;
    ref_pk_r   <= ref_pk_nxt;
    test_pk_r  <= test_pk_nxt;
    m1_r       <= m1_nxt;
    ref_rms_r  <= ref_rms_nxt;
    test_rms_r <= test_rms_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    quo_r      <= quo_nxt;
    sat_r      <= sat_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    period_nxt    = period_r;
    delay_nxt     = delay_r;
    ref_pk_nxt    = ref_pk_r;
    test_pk_nxt   = test_pk_r;
    sel_nxt       = sel_r;
    m1_nxt        = m1_r;
    ref_rms_nxt   = ref_rms_r;
    test_rms_nxt  = test_rms_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    sat_nxt       = sat_r;
    zero_nxt      = zero_r;
    job_pop       = 1'b0;
    case (state_r)
      acprm_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          period_nxt  = COUNT_WIDTH'(job.period);
          delay_nxt   = COUNT_WIDTH'(job.delay);
          ref_pk_nxt  = ADC_BITS'(job.ref_peak);
          test_pk_nxt = ADC_BITS'(job.test_peak);
          sel_nxt     = 1'b0;
          state_nxt   = acprm_pkg::BK_MUL_A;
        end
      end
      acprm_pkg::BK_MUL_A: begin
        m1_nxt    = M1_W'(peak_sel) * M1_W'(full_scale_mv);
        state_nxt = acprm_pkg::BK_MUL_B;
      end
      acprm_pkg::BK_MUL_B: begin
        if (sel_r) begin
          test_rms_nxt = rms_val;
          state_nxt    = acprm_pkg::BK_PH_MUL;
        end else begin
          ref_rms_nxt = rms_val;
          sel_nxt     = 1'b1;
          state_nxt   = acprm_pkg::BK_MUL_A;
        end
      end
      acprm_pkg::BK_PH_MUL: begin
        // The high part of the numerator stays below the period when the
        // delay is under one period, so sixteen quotient bits suffice.
        rem_nxt   = num[NUM_W-1:16];
        low_nxt   = num[15:0];
        quo_nxt   = '0;
        step_nxt  = '0;
        zero_nxt  = (period_r == '0);
        sat_nxt   = (delay_r >= period_r);
        state_nxt = acprm_pkg::BK_DIV;
      end
      acprm_pkg::BK_DIV: begin
        rem_nxt  = trial_ge ? COUNT_WIDTH'(trial - {1'b0, period_r}) : trial[COUNT_WIDTH-1:0];
        low_nxt  = {low_r[14:0], 1'b0};
        quo_nxt  = {quo_r[14:0], trial_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == 4'(acprm_pkg::DIV_STEPS - 1)) state_nxt = acprm_pkg::BK_OUT;
      end
      acprm_pkg::BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.period_ticks   = (per32 > 32'(acprm_pkg::OUT24_MAX)) ?
                                        acprm_pkg::OUT24_MAX : per32[23:0];
          out_data_nxt.ref_rms_mv     = ref_rms_r;
          out_data_nxt.test_rms_mv    = test_rms_r;
          out_data_nxt.delay_ticks    = (dly32 > 32'(acprm_pkg::OUT24_MAX)) ?
                                        acprm_pkg::OUT24_MAX : dly32[23:0];
          out_data_nxt.phase_centideg = phase_val;
          state_nxt                   = acprm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = acprm_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ACPRM_ASSERT_IMPLY(a_pop_only_idle, job_pop, state_r == acprm_pkg::BK_IDLE)
  `ACPRM_ASSERT_IMPLY(a_phase_range, out_valid_r, out_data_r.phase_centideg <= acprm_pkg::PHASE_MAX)
  `ACPRM_ASSERT_NEXT(a_result_loaded, (state_r == acprm_pkg::BK_OUT) && !(out_valid_r && out_stall), out_valid_r && (state_r == acprm_pkg::BK_IDLE))

endmodule

`default_nettype wire

FILE: hw/rtl/ac_phase_and_rms_meter_top.sv
// ----------------------------------------------------------------------------
// ac_phase_and_rms_meter_top
// Zero-crossing phase meter with peak-based RMS readout.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in_     | input     | in_valid / in_stall | acprm_pkg::in_item_t
//   out_    | output    | out_valid/out_stall | acprm_pkg::out_item_t
//   cfg_    | input     | cfg_valid/cfg_ready | full_scale_mv, 13 bits
//
// A tick is taken every cycle unless the two-entry job queue is full.
// The back part takes one job at a time, in this order: one
// dequeue, two rounds of the shared RMS multiplier, one numerator multiply,
// sixteen divide steps of the phase divider and one output load.
// Synchronous active-low reset returns the sequencer to waiting for the
// reference low level and sets full scale to 3300 mV.
// The result register holds while out_stall is high; the sequencer keeps
// taking ticks until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_phase_and_rms_meter_top #(
  parameter int COUNT_WIDTH = 24,
  parameter int ADC_BITS    = 10
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  acprm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output acprm_pkg::out_item_t out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [12:0]          cfg_data
);

  logic [12:0]          full_scale_r, full_scale_nxt;
  acprm_pkg::job_push_t push;
  logic                 q_full;
  logic                 head_valid;
  acprm_pkg::job_t      head;
  logic                 job_pop;

  // Full-scale register write.
  assign cfg_ready      = 1'b1;
  assign full_scale_nxt = (cfg_valid && cfg_ready) ? cfg_data : full_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= acprm_pkg::FS_RESET;
    end else begin
      full_scale_r <= full_scale_nxt;
    end
  end

  acprm_front #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADC_BITS    (ADC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  acprm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (job_pop)
  );

  acprm_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADC_BITS    (ADC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .full_scale_mv (full_scale_r),
    .job_valid     (head_valid),
    .job           (head),
    .job_pop       (job_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Phase and RMS meter testbench
// Feeds timer-tick requests into ac_phase_and_rms_meter_top and checks every
// measurement it returns against a cycle-free model of the sequencer, the RMS
// scaling and the phase division. A short table of hand-built ticks comes
// first, then square-wave bursts of random shape with some noise, under
// several full-scale settings, random idling on both channels and one long
// hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import acprm_pkg::*;

  localparam int IDLE_PCT    = 11;
  localparam int SETTLE      = 100;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_AT     = 12;
  localparam int HOLD_CYCLES = 800;
  localparam int PHASES      = 5;
  localparam int PHASE_TICKS = 100;
  localparam int PHASE_MEAS  = 8;
  localparam int RMS_SHIFT   = 26;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  // One row of the hand-built tick sequence, with an optional fixed answer.
  typedef struct packed {
    logic      typed;
    out_item_t want;
    in_item_t  tick;
  } dir_row_t;

  localparam out_item_t NO_WANT = '0;

  // Two complete measurements with a period of two ticks. The first has the
  // test signal already high at the reference rise and zero peaks; the second
  // has full-code peaks and a delay of a whole period, so the phase clamps.
  localparam dir_row_t DIR_ROWS [26] = '{
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd1023, 10'd1023},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd1023, 10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd1023},
    {1'b0, NO_WANT, 1'b0, 1'b1, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd1023},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd1023, 10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b1, 10'd1023, 10'd1023},
    {1'b0, NO_WANT, 1'b0, 1'b1, 10'd1023, 10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd0,    10'd0},
    {1'b1, {24'd2, 13'd0, 13'd0, 24'd0, 16'd0}, 1'b1, 1'b1, 10'd0, 10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b1, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b1, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd1023, 10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b1, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b1, 10'd0,    10'd1023},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b0, 1'b0, 10'd0,    10'd0},
    {1'b0, NO_WANT, 1'b1, 1'b1, 10'd0,    10'd0}
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data  = '0;

  // Shared run state.
  out_item_t pending_readings[$];
  bit        failed = 1'b0;
  bit        calm   = 1'b0;

  // Model state of the meter.
  seq_phase_t  mtr_seq;
  logic [23:0] mtr_ticks;
  logic [23:0] mtr_period;
  logic [9:0]  mtr_ref_peak;
  logic [9:0]  mtr_test_peak;
  logic [12:0] mtr_full_scale;

  // Shape of the current square-wave burst.
  int wv_per, wv_ref_hi, wv_test_hi, wv_test_off, wv_pos, wv_left;
  bit wv_noisy;

  ac_phase_and_rms_meter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [23:0] bump(input logic [23:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 24'd1;
  endfunction

  // Peak code to RMS millivolts: code * full scale / 1024 / sqrt(2), rounded.
  function automatic logic [12:0] rms_of_peak(input logic [9:0] code);
    logic [63:0] p;
    p = 64'(code) * 64'(mtr_full_scale) * 64'(INV_SQRT2_Q16);
    p = (p + (64'd1 << (RMS_SHIFT - 1))) >> RMS_SHIFT;
    return (p > 64'(RMS_MAX)) ? RMS_MAX : p[12:0];
  endfunction

  // Advances the sequencer by one tick; returns 1 when a measurement is done.
  function automatic bit meter_tick(input in_item_t t, output out_item_t r);
    bit          done;
    logic [23:0] dly;
    logic [63:0] ph;
    done = 1'b0;
    dly  = '0;
    r    = '0;
    case (mtr_seq)
      SEQ_PER_WAIT_LOW: if (!t.ref_level) mtr_seq = SEQ_PER_WAIT_HIGH;
      SEQ_RPK_WAIT_LOW: if (!t.ref_level) mtr_seq = SEQ_RPK_WAIT_HIGH;
      SEQ_DLY_WAIT_LOW: if (!t.ref_level) mtr_seq = SEQ_DLY_WAIT_HIGH;
      SEQ_TPK_WAIT_LOW: if (!t.test_level) mtr_seq = SEQ_TPK_WAIT_HIGH;
      SEQ_PER_WAIT_HIGH: if (t.ref_level) begin
        mtr_ticks = '0;
        mtr_seq   = SEQ_PER_CNT_HIGH;
      end
      SEQ_RPK_WAIT_HIGH: if (t.ref_level) begin
        mtr_ticks = '0;
        mtr_seq   = SEQ_RPK_QUARTER;
      end
      SEQ_TPK_WAIT_HIGH: if (t.test_level) begin
        mtr_ticks = '0;
        mtr_seq   = SEQ_TPK_QUARTER;
      end
      SEQ_PER_CNT_HIGH: begin
        mtr_ticks = bump(mtr_ticks);
        if (!t.ref_level) mtr_seq = SEQ_PER_CNT_LOW;
      end
      SEQ_PER_CNT_LOW: begin
        mtr_ticks = bump(mtr_ticks);
        if (t.ref_level) begin
          mtr_period = mtr_ticks;
          mtr_seq    = SEQ_RPK_WAIT_LOW;
        end
      end
      SEQ_RPK_QUARTER: begin
        mtr_ticks = bump(mtr_ticks);
        if (mtr_ticks >= (mtr_period >> 2)) begin
          mtr_ref_peak = t.ref_sample;
          mtr_seq      = SEQ_TPK_WAIT_LOW;
        end
      end
      SEQ_TPK_QUARTER: begin
        mtr_ticks = bump(mtr_ticks);
        if (mtr_ticks >= (mtr_period >> 2)) begin
          mtr_test_peak = t.test_sample;
          mtr_seq       = SEQ_DLY_WAIT_LOW;
        end
      end
      SEQ_DLY_WAIT_HIGH: if (t.ref_level) begin
        mtr_ticks = '0;
        // Test already high at the reference rise gives a zero delay.
        if (t.test_level) done = 1'b1;
        else mtr_seq = SEQ_DLY_COUNT;
      end
      SEQ_DLY_COUNT: begin
        mtr_ticks = bump(mtr_ticks);
        if (t.test_level) begin
          done = 1'b1;
          dly  = mtr_ticks;
        end
      end
      default: mtr_seq = SEQ_PER_WAIT_LOW;
    endcase
    if (done) begin
      mtr_seq = SEQ_PER_WAIT_LOW;
      ph = '0;
      if (mtr_period != '0) begin
        ph = (64'(dly) * 64'(PHASE_SCALE)) / 64'(mtr_period);
        if (ph > 64'(PHASE_MAX)) ph = 64'(PHASE_MAX);
      end
      r.period_ticks   = mtr_period;
      r.ref_rms_mv     = rms_of_peak(mtr_ref_peak);
      r.test_rms_mv    = rms_of_peak(mtr_test_peak);
      r.delay_ticks    = dly;
      r.phase_centideg = ph[15:0];
    end
    return done;
  endfunction

  // Sample codes lean toward the two extremes now and then.
  function automatic logic [9:0] pick_code();
    case ($urandom_range(7))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // Next tick of a random square-wave burst; a few bursts are pure noise.
  function automatic in_item_t next_wave_tick();
    in_item_t t;
    if (wv_left == 0) begin
      wv_per      = ($urandom_range(19) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(2, 24);
      wv_ref_hi   = $urandom_range(1, wv_per - 1);
      wv_test_hi  = $urandom_range(1, wv_per - 1);
      wv_test_off = $urandom_range(0, wv_per - 1);
      wv_pos      = $urandom_range(0, wv_per - 1);
      wv_noisy    = ($urandom_range(7) == 0);
      wv_left     = wv_noisy ? $urandom_range(4, 40) : wv_per * $urandom_range(3, 10);
    end
    wv_left--;
    if (wv_noisy) begin
      t.ref_level  = $urandom_range(1);
      t.test_level = $urandom_range(1);
    end else begin
      t.ref_level  = (wv_pos < wv_ref_hi);
      t.test_level = (((wv_pos + wv_per - wv_test_off) % wv_per) < wv_test_hi);
    end
    wv_pos        = (wv_pos + 1) % wv_per;
    t.ref_sample  = pick_code();
    t.test_sample = pick_code();
    return t;
  endfunction

  task automatic write_full_scale(input logic [12:0] mv);
    cfg_valid <= 1'b1;
    cfg_data  <= mv;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mtr_full_scale = mv;
  endtask

  // Offers one tick request and records what it should produce once taken.
  task automatic send_tick(input in_item_t t, input bit typed, input out_item_t fixed,
                           output bit made);
    out_item_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    made = meter_tick(t, r);
    if (typed) begin
      pending_readings.push_back(fixed);
      made = 1'b1;
    end else if (made) begin
      pending_readings.push_back(r);
    end
  endtask

  // Stops offering and waits until the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Stimulus: reset, table walk, then random phases under several settings.
  initial begin : stimulus
    bit          made;
    int          n_ticks;
    int          n_meas;
    logic [12:0] fs;
    mtr_seq        = SEQ_PER_WAIT_LOW;
    mtr_ticks      = '0;
    mtr_period     = '0;
    mtr_ref_peak   = '0;
    mtr_test_peak  = '0;
    mtr_full_scale = FS_RESET;
    wv_left        = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_full_scale(13'd5000);
    foreach (DIR_ROWS[i]) begin
      send_tick(DIR_ROWS[i].tick, DIR_ROWS[i].typed, DIR_ROWS[i].want, made);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: fs = 13'd0;
        1: fs = 13'd8191;
        2: fs = 13'($urandom_range(1, 4999));
        3: fs = FS_RESET;
        default: fs = 13'd5000;
      endcase
      write_full_scale(fs);
      // One phase runs without any idling on either side.
      calm    = (ph == 2);
      n_ticks = 0;
      n_meas  = 0;
      while (n_ticks < PHASE_TICKS || n_meas < PHASE_MEAS) begin
        send_tick(next_wave_tick(), 1'b0, NO_WANT, made);
        n_ticks++;
        if (made) n_meas++;
      end
    end
    drain();
    if (!failed && pending_readings.size() == 0) begin
      $display("ac_phase_and_rms_meter_top: match");
    end else begin
      $display("ac_phase_and_rms_meter_top: mismatch");
    end
    $finish;
  end

  // Result side: checks each accepted request and drives the stall.
  initial begin : result_sink
    int        hold_left;
    int        seen;
    out_item_t want;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        seen++;
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none got %p", $time, out_data);
          failed = 1'b1;
        end else begin
          want = pending_readings.pop_front();
          check_field("period_ticks", want.period_ticks, out_data.period_ticks);
          check_field("ref_rms_mv", 24'(want.ref_rms_mv), 24'(out_data.ref_rms_mv));
          check_field("test_rms_mv", 24'(want.test_rms_mv), 24'(out_data.test_rms_mv));
          check_field("delay_ticks", want.delay_ticks, out_data.delay_ticks);
          check_field("phase_centideg", 24'(want.phase_centideg),
                      24'(out_data.phase_centideg));
        end
        // One long hold-off lets the job queue fill and back up the input.
        if (seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Ends the run when no channel has moved a request for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("ac_phase_and_rms_meter_top: mismatch");
    $finish;
  end

endmodule
